// ----- src/spmg_pkg.sv -----
// Shared constants, derived sizes and the controller-to-datapath command type.
package spmg_pkg;

  localparam int DATA_W = 31;
  localparam int MULT_W = 15;
  localparam int PROD_W = DATA_W + MULT_W;

  localparam longint unsigned MODULUS = 64'd2147483647;
  localparam longint unsigned MULT    = 64'd16807;

  localparam int TABLE_DEPTH = 32;
  localparam int WARMUP      = 8;
  localparam int STEPS       = TABLE_DEPTH + WARMUP;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STEPS);

  // Index = previous result / DIVISOR, done as a multiply by RECIP and one correction.
  localparam longint unsigned DIVISOR = 64'd1 + (MODULUS - 64'd1) / TABLE_DEPTH;
  localparam longint unsigned RECIP   = (64'd1 << DATA_W) / DIVISOR + 64'd1;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int QMUL_W  = DATA_W + RECIP_W;
  localparam int Q_W     = $clog2(RECIP + TABLE_DEPTH + 1);

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef struct packed {
    logic              load_seed;
    logic              mul;
    logic              red;
    logic              rd;
    logic              wr;
    logic              wr_init;
    logic [ADDR_W-1:0] init_addr;
    logic              div_from_lcg;
    logic              qmul_en;
    logic              idx_en;
    logic              out_load;
  } spmg_cmd_t;

endpackage

// ----- src/spmg_if.sv -----
// Request and response channel interfaces.
interface spmg_req_if;
  import spmg_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] seed;
  modport source (output valid, cmd, seed, input ready);
  modport sink (input valid, cmd, seed, output ready);
endinterface

interface spmg_rsp_if;
  import spmg_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] deviate;
  modport source (output valid, deviate, input ready);
  modport sink (input valid, deviate, output ready);
endinterface

// ----- src/spmg_datapath.sv -----
// Generator state, modular multiplier, shuffle memory and index divider.
module spmg_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  spmg_pkg::spmg_cmd_t        ctl,
  input  logic [spmg_pkg::DATA_W-1:0] seed,
  output logic [spmg_pkg::DATA_W-1:0] deviate
);
  import spmg_pkg::*;

  logic [DATA_W-1:0] lcg;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] shuf_mem [TABLE_DEPTH];
  logic [QMUL_W-1:0] qmul;
  logic [ADDR_W-1:0] idx;

  logic [DATA_W-1:0] seed_fixed;
  logic [DATA_W:0]   fold;
  logic [DATA_W-1:0] reduced;
  logic [DATA_W-1:0] div_x;
  logic [ADDR_W-1:0] wr_addr;
  logic [QMUL_W-1:0] qd;
  logic [Q_W-1:0]    q_est;
  logic [Q_W-1:0]    q_fix;
  logic [Q_W-1:0]    q_clamp;

  // A seed congruent to zero starts from one.
  assign seed_fixed = (seed == '0 || seed == DATA_W'(MODULUS)) ? DATA_W'(1) : seed;

  // Fold the high bits back in, since 2^31 = 1 modulo the modulus.
  assign fold    = {1'b0, prod[DATA_W-1:0]} + (DATA_W + 1)'(prod[PROD_W-1:DATA_W]);
  assign reduced = (fold >= (DATA_W + 1)'(MODULUS)) ?
                   DATA_W'(fold - (DATA_W + 1)'(MODULUS)) : fold[DATA_W-1:0];

  assign div_x   = ctl.div_from_lcg ? lcg : rd_data;
  assign wr_addr = ctl.wr_init ? ctl.init_addr : idx;

  // Estimate is exact or one high; drop it by one where it overshoots.
  assign q_est   = Q_W'(qmul[QMUL_W-1:DATA_W]);
  assign qd      = QMUL_W'(qmul[QMUL_W-1:DATA_W]) * QMUL_W'(DIVISOR);
  assign q_fix   = (qd > QMUL_W'(div_x)) ? q_est - Q_W'(1) : q_est;
  assign q_clamp = (q_fix >= Q_W'(TABLE_DEPTH)) ? Q_W'(TABLE_DEPTH - 1) : q_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg <= DATA_W'(1);
    end else if (ctl.load_seed) begin
      lcg <= seed_fixed;
    end else if (ctl.red) begin
      lcg <= reduced;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= PROD_W'(lcg) * PROD_W'(MULT);
    end
    if (ctl.qmul_en) begin
      qmul <= QMUL_W'(div_x) * QMUL_W'(RECIP);
    end
    if (ctl.idx_en) begin
      idx <= q_clamp[ADDR_W-1:0];
    end
    if (ctl.out_load) begin
      deviate <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      shuf_mem[wr_addr] <= lcg;
    end
    if (ctl.rd) begin
      rd_data <= shuf_mem[idx];
    end
  end

endmodule

// ----- src/spmg_ctrl.sv -----
// Sequencer for seeding, table fill and draws, with the output valid flag.
module spmg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_cmd,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output spmg_pkg::spmg_cmd_t ctl
);
  import spmg_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    INIT_MUL,
    INIT_RED,
    INIT_WR,
    IDX_MUL,
    IDX_FIX,
    DRAW_MUL,
    DRAW_RED,
    DRAW_WR
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  step;
  logic              seeded;
  logic              accept;
  logic              slot_free;
  logic              in_table;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign in_table  = (step < CNT_W'(TABLE_DEPTH));

  always_comb begin
    ctl = '0;
    ctl.init_addr = step[ADDR_W-1:0];
    case (state)
      IDLE: begin
        if (accept) begin
          if (req_cmd == CMD_RESEED) begin
            ctl.load_seed = 1'b1;
          end else if (seeded) begin
            ctl.mul = 1'b1;
            ctl.rd  = 1'b1;
          end
        end
      end
      INIT_MUL: ctl.mul = 1'b1;
      INIT_RED: ctl.red = 1'b1;
      INIT_WR: begin
        ctl.wr      = 1'b1;
        ctl.wr_init = 1'b1;
      end
      IDX_MUL: begin
        ctl.qmul_en      = 1'b1;
        ctl.div_from_lcg = 1'b1;
      end
      IDX_FIX: begin
        ctl.idx_en       = 1'b1;
        ctl.div_from_lcg = 1'b1;
      end
      DRAW_MUL: begin
        ctl.mul = 1'b1;
        ctl.rd  = 1'b1;
      end
      DRAW_RED: begin
        ctl.red     = 1'b1;
        ctl.qmul_en = 1'b1;
      end
      DRAW_WR: begin
        if (slot_free) begin
          ctl.wr       = 1'b1;
          ctl.idx_en   = 1'b1;
          ctl.out_load = 1'b1;
        end
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      seeded    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            if (req_cmd == CMD_RESEED || !seeded) begin
              step  <= CNT_W'(STEPS - 1);
              state <= INIT_MUL;
            end else begin
              state <= DRAW_RED;
            end
          end
        end
        INIT_MUL: state <= INIT_RED;
        INIT_RED: begin
          if (in_table) begin
            state <= INIT_WR;
          end else begin
            step  <= step - CNT_W'(1);
            state <= INIT_MUL;
          end
        end
        INIT_WR: begin
          // The last fill value is table entry zero and becomes the previous result.
          if (step == '0) begin
            seeded <= 1'b1;
            state  <= IDX_MUL;
          end else begin
            step  <= step - CNT_W'(1);
            state <= INIT_MUL;
          end
        end
        IDX_MUL:  state <= IDX_FIX;
        IDX_FIX:  state <= DRAW_MUL;
        DRAW_MUL: state <= DRAW_RED;
        DRAW_RED: state <= DRAW_WR;
        DRAW_WR: begin
          // Hold until the output register is free.
          if (slot_free) begin
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- src/shuffled_park_miller_generator_unit.sv -----
// Top level of the shuffled Park-Miller generator.
//
//   channel  dir  payload                     accepted when
//   req      in   cmd (1 b), seed (31 b)      req.valid && req.ready
//   rsp      out  deviate (31 b)              rsp.valid && rsp.ready
//
// A draw runs the multiply and memory read at acceptance, then the fold reduction, then the
// write-back that latches the next table index; the result is valid from the write-back on.
// A reseed, or the first draw after reset, runs 8 warm-up steps of multiply and reduction,
// 32 fill steps that also write the table, index multiply and correction, then a draw.
// Reset is synchronous; the generator state returns to one and the table is refilled
// on the next draw. A result held by a stalled rsp blocks only the next write-back.
module shuffled_park_miller_generator_unit (
  input logic       clk,
  input logic       rst,
  spmg_req_if.sink  req,
  spmg_rsp_if.source rsp
);
  import spmg_pkg::*;

  spmg_cmd_t ctl;

  spmg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  spmg_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .seed    (req.seed),
    .deviate (rsp.deviate)
  );

endmodule
